// File: rtl/bdc_pkg.sv
// Shared types, codes and constants for the de Casteljau curve evaluator.
package bdc_pkg;

    localparam int COORD_W              = 16;
    localparam int T_W                  = 17;
    localparam int T_FRAC               = 16;
    localparam int PROD_W               = COORD_W + T_W + 2;
    localparam int MAX_CTRL_POINTS_DEF  = 64;
    localparam logic [T_W-1:0] T_ONE    = T_W'(1) << T_FRAC;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_EVAL   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PASS,
        S_DRAIN,
        S_FINAL,
        S_FWAIT,
        S_COMMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic rd_work;
        logic rd_first;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic busy;
        logic out_free;
        logic cnt_zero;
        logic cnt_one;
        cmd_t cmd;
    } dp_stat_t;

endpackage

// File: rtl/bdc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module bdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/bdc_ctrl.sv
// Controller: sequences requests, reduction passes and result hand-off.
module bdc_ctrl
    import bdc_pkg::*;
#(
    parameter int MAX_CTRL_POINTS = MAX_CTRL_POINTS_DEF,
    parameter int CNT_W           = $clog2(MAX_CTRL_POINTS + 1),
    parameter int ADDR_W          = $clog2(MAX_CTRL_POINTS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dp_stat_t          stat,
    input  logic [CNT_W-1:0]  count,
    output dp_cmd_t           cmd,
    output logic [ADDR_W-1:0] rd_addr
);

    ctrl_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  pass_n_reg, pass_n_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic              src_work_reg, src_work_next;

    // State and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pass_n_reg   <= '0;
            rd_idx_reg   <= '0;
            src_work_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pass_n_reg   <= pass_n_next;
            rd_idx_reg   <= rd_idx_next;
            src_work_reg <= src_work_next;
        end
    end

    assign rd_addr = rd_idx_reg;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        pass_n_next   = pass_n_reg;
        rd_idx_next   = rd_idx_reg;
        src_work_next = src_work_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.rd_work   = src_work_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                src_work_next = 1'b0;
                rd_idx_next   = '0;
                if (stat.cmd == CMD_EVAL && !stat.cnt_zero)
                begin
                    if (stat.cnt_one)
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        pass_n_next = count;
                        state_next  = S_PASS;
                    end
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_PASS:
            begin
                // Stream one point per cycle through the lerp unit
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (rd_idx_reg == '0);
                if (CNT_W'(rd_idx_reg) == pass_n_reg - CNT_W'(1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + ADDR_W'(1);
                end
            end
            S_DRAIN:
            begin
                // Let the pass land in the work store before the next one reads it
                if (!stat.busy)
                begin
                    rd_idx_next   = '0;
                    src_work_next = 1'b1;
                    if (pass_n_reg == CNT_W'(2))
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        pass_n_next = pass_n_reg - CNT_W'(1);
                        state_next  = S_PASS;
                    end
                end
            end
            S_FINAL:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = 1'b1;
                state_next   = S_FWAIT;
            end
            S_FWAIT:
            begin
                if (!stat.busy)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/bdc_dp.sv
// Datapath: point stores, request registers, lerp unit and result register.
module bdc_dp
    import bdc_pkg::*;
#(
    parameter int MAX_CTRL_POINTS = MAX_CTRL_POINTS_DEF,
    parameter int CNT_W           = $clog2(MAX_CTRL_POINTS + 1),
    parameter int ADDR_W          = $clog2(MAX_CTRL_POINTS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  logic [ADDR_W-1:0]  rd_addr,
    output dp_stat_t           stat,
    output logic [CNT_W-1:0]   count,
    input  logic [1:0]         command,
    input  logic [COORD_W-1:0] point_x,
    input  logic [COORD_W-1:0] point_y,
    input  logic [T_W-1:0]     param_t,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COORD_W-1:0] curve_x,
    output logic [COORD_W-1:0] curve_y,
    output logic [1:0]         status,
    output logic [CNT_W-1:0]   point_count
);

    localparam int PT_W = 2 * COORD_W;

    // Request registers
    cmd_t               cmd_reg;
    logic [COORD_W-1:0] px_reg, py_reg;
    logic [T_W-1:0]     t_reg;

    logic [CNT_W-1:0]   cnt_reg;
    logic               cnt_full;

    // Lerp pipeline
    logic               s1_v_reg, s1_first_reg, s1_work_reg;
    logic [ADDR_W-1:0]  s1_waddr_reg;
    logic               s2_v_reg;
    logic [ADDR_W-1:0]  s2_waddr_reg;
    logic [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic [COORD_W-1:0] a_x_reg, a_y_reg;
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg;

    logic [PT_W-1:0]    ctrl_rdata, work_rdata, cur_pt, wr_pt;
    logic [COORD_W-1:0] cur_x, cur_y, wr_x, wr_y;
    logic signed [COORD_W:0]    diff_x, diff_y;
    logic signed [PROD_W-1:0]   prod_x_next, prod_y_next;
    logic               ctrl_we;

    // Result register
    logic               out_valid_reg;
    logic [COORD_W-1:0] res_x_reg, res_y_reg;
    status_t            res_stat_reg;
    logic [CNT_W-1:0]   res_cnt_reg;

    assign cnt_full = (cnt_reg == CNT_W'(MAX_CTRL_POINTS));
    assign ctrl_we  = cmd.commit && cmd_reg == CMD_APPEND && !cnt_full;

    bdc_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_CTRL_POINTS)
    ) u_ctrl_ram (
        .clk   (clk),
        .we    (ctrl_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata ({px_reg, py_reg}),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (ctrl_rdata)
    );

    bdc_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_CTRL_POINTS)
    ) u_work_ram (
        .clk   (clk),
        .we    (s2_v_reg),
        .waddr (s2_waddr_reg),
        .wdata (wr_pt),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (work_rdata)
    );

    // Pick the store this read came from
    assign cur_pt = s1_work_reg ? work_rdata : ctrl_rdata;
    assign cur_x  = cur_pt[PT_W-1:COORD_W];
    assign cur_y  = cur_pt[COORD_W-1:0];

    // (b - a) * t, floored later by the arithmetic shift
    assign diff_x      = $signed({1'b0, cur_x}) - $signed({1'b0, prev_x_reg});
    assign diff_y      = $signed({1'b0, cur_y}) - $signed({1'b0, prev_y_reg});
    assign prod_x_next = PROD_W'(diff_x) * PROD_W'($signed({1'b0, t_reg}));
    assign prod_y_next = PROD_W'(diff_y) * PROD_W'($signed({1'b0, t_reg}));

    // a + floor(prod / 2^16); the sum stays between a and b
    assign wr_x  = a_x_reg + prod_x_reg[T_FRAC +: COORD_W];
    assign wr_y  = a_y_reg + prod_y_reg[T_FRAC +: COORD_W];
    assign wr_pt = {wr_x, wr_y};

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.rd_en;
            s2_v_reg <= s1_v_reg && !s1_first_reg;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // Update the held count on commit
            if (cmd.commit)
            begin
                unique case (cmd_reg)
                    CMD_APPEND:
                    begin
                        cnt_reg <= cnt_full ? '0 : cnt_reg + CNT_W'(1);
                    end
                    CMD_REMOVE:
                    begin
                        if (cnt_reg != '0)
                        begin
                            cnt_reg <= cnt_reg - CNT_W'(1);
                        end
                    end
                    CMD_CLEAR:
                    begin
                        cnt_reg <= '0;
                    end
                    CMD_EVAL:
                    begin
                        cnt_reg <= cnt_reg;
                    end
                    default:
                    begin
                        cnt_reg <= cnt_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= cmd_t'(command);
            px_reg  <= point_x;
            py_reg  <= point_y;
            t_reg   <= (param_t > T_ONE) ? T_ONE : param_t;
        end
        if (cmd.rd_en)
        begin
            s1_first_reg <= cmd.rd_first;
            s1_work_reg  <= cmd.rd_work;
            s1_waddr_reg <= rd_addr - ADDR_W'(1);
        end
        // Hold each arriving point as the left end of the next lerp
        if (s1_v_reg)
        begin
            prev_x_reg   <= cur_x;
            prev_y_reg   <= cur_y;
            a_x_reg      <= prev_x_reg;
            a_y_reg      <= prev_y_reg;
            prod_x_reg   <= prod_x_next;
            prod_y_reg   <= prod_y_next;
            s2_waddr_reg <= s1_waddr_reg;
        end
        if (cmd.commit)
        begin
            res_x_reg    <= '0;
            res_y_reg    <= '0;
            res_stat_reg <= STAT_DONE;
            res_cnt_reg  <= cnt_reg;
            unique case (cmd_reg)
                CMD_APPEND:
                begin
                    if (cnt_full)
                    begin
                        res_stat_reg <= STAT_OVERFLOW;
                        res_cnt_reg  <= '0;
                    end
                    else
                    begin
                        res_cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                CMD_REMOVE:
                begin
                    if (cnt_reg != '0)
                    begin
                        res_cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                CMD_CLEAR:
                begin
                    res_cnt_reg <= '0;
                end
                CMD_EVAL:
                begin
                    if (cnt_reg == '0)
                    begin
                        res_stat_reg <= STAT_EMPTY;
                    end
                    else
                    begin
                        res_x_reg <= prev_x_reg;
                        res_y_reg <= prev_y_reg;
                    end
                end
                default:
                begin
                    res_stat_reg <= STAT_DONE;
                end
            endcase
        end
    end

    assign stat.busy     = s1_v_reg || s2_v_reg;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.cnt_zero = (cnt_reg == '0);
    assign stat.cnt_one  = (cnt_reg == CNT_W'(1));
    assign stat.cmd      = cmd_reg;
    assign count         = cnt_reg;

    assign out_valid   = out_valid_reg;
    assign curve_x     = res_x_reg;
    assign curve_y     = res_y_reg;
    assign status      = res_stat_reg;
    assign point_count = res_cnt_reg;

endmodule

// File: rtl/bezier_de_casteljau_eval.sv
// Top level of the de Casteljau Bezier curve evaluator.
//
// Holds up to MAX_CTRL_POINTS 2-D control points (unsigned Q12.4) and takes one
// request at a time: append, remove last, clear, or evaluate at t (Q1.16, values
// above 1.0 saturate). Evaluating n >= 2 points uses one shared lerp unit per
// coordinate that reduces the chain one pair per cycle, each pass streaming through
// the work RAM and then draining its three-stage read/multiply/write pipeline
// before the next pass reads it back. A stalled output adds its stall to the
// request that follows. A new request is taken while the previous result still
// waits in the output register. Evaluating an empty list returns status 1;
// appending to a full list clears it and returns status 2.
module bezier_de_casteljau_eval
    import bdc_pkg::*;
#(
    parameter int MAX_CTRL_POINTS = MAX_CTRL_POINTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           command,
    input  logic [COORD_W-1:0]                   point_x,
    input  logic [COORD_W-1:0]                   point_y,
    input  logic [T_W-1:0]                       param_t,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [COORD_W-1:0]                   curve_x,
    output logic [COORD_W-1:0]                   curve_y,
    output logic [1:0]                           status,
    output logic [$clog2(MAX_CTRL_POINTS+1)-1:0] point_count
);

    localparam int CNT_W  = $clog2(MAX_CTRL_POINTS + 1);
    localparam int ADDR_W = $clog2(MAX_CTRL_POINTS);

    dp_cmd_t           dp_cmd;
    dp_stat_t          dp_stat;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] rd_addr;

    bdc_ctrl #(
        .MAX_CTRL_POINTS (MAX_CTRL_POINTS),
        .CNT_W           (CNT_W),
        .ADDR_W          (ADDR_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .count    (count),
        .cmd      (dp_cmd),
        .rd_addr  (rd_addr)
    );

    bdc_dp #(
        .MAX_CTRL_POINTS (MAX_CTRL_POINTS),
        .CNT_W           (CNT_W),
        .ADDR_W          (ADDR_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .rd_addr     (rd_addr),
        .stat        (dp_stat),
        .count       (count),
        .command     (command),
        .point_x     (point_x),
        .point_y     (point_y),
        .param_t     (param_t),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .status      (status),
        .point_count (point_count)
    );

    // The lerp pipeline is empty whenever a new request can enter
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !dp_stat.busy)
        else $error("lerp pipeline busy while idle");

    // The held count never passes the list size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> point_count <= CNT_W'(MAX_CTRL_POINTS))
        else $error("point count above list size");

    // An overflowing append leaves the list empty
    a_overflow_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_OVERFLOW |-> point_count == '0)
        else $error("overflow result with nonzero count");

    // Evaluating an empty list returns the origin and an empty list
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_EMPTY |->
            curve_x == '0 && curve_y == '0 && point_count == '0)
        else $error("empty evaluation with nonzero fields");

endmodule

// File: tb/sv/bezier_de_casteljau_eval_tb.sv
// Testbench for the de Casteljau curve evaluator: random request streams checked by a predictor.
`timescale 1ns / 1ps

module bezier_de_casteljau_eval_tb;
    import bdc_pkg::*;

    localparam int MAX_PTS     = MAX_CTRL_POINTS_DEF;
    localparam int TOTAL_REQS  = 280;
    localparam int STUCK_LIMIT = 20000;
    localparam int SETTLE_CYC  = 50;

    typedef struct {
        cmd_t         cmd;
        logic [15:0]  px;
        logic [15:0]  py;
        logic [16:0]  t;
        bit           hold_for_drain;
    } curve_req_t;

    typedef struct {
        logic [15:0]  cx;
        logic [15:0]  cy;
        status_t      st;
        logic [6:0]   count;
    } curve_resp_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         in_ready;
    logic [1:0]   command = CMD_CLEAR;
    logic [15:0]  point_x = '0;
    logic [15:0]  point_y = '0;
    logic [16:0]  param_t = '0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    logic [15:0]  curve_x;
    logic [15:0]  curve_y;
    logic [1:0]   status;
    logic [6:0]   point_count;

    curve_req_t   req_q[$];
    curve_resp_t  resp_q[$];
    logic         results_drained = 1'b1;
    int           mismatches = 0;
    int           stuck_cycles = 0;

    // Predictor copy of the control point list
    logic [15:0]  pts_x [MAX_PTS];
    logic [15:0]  pts_y [MAX_PTS];
    int           held_pts = 0;

    // Sender and receiver pacing
    int           burst_left = 1;
    int           gap_left = 0;
    int           stall_left = 0;
    int           calm_left = 0;
    curve_req_t   next_req;

    bezier_de_casteljau_eval i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .point_x     (point_x),
        .point_y     (point_y),
        .param_t     (param_t),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .status      (status),
        .point_count (point_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // a + floor((b - a) * t / 2^16); arithmetic shift gives the floor
    function automatic logic [15:0] lerp_coord(logic [15:0] a, logic [15:0] b, logic [16:0] t);
        longint prod;
        longint r;
        prod = (longint'(b) - longint'(a)) * longint'(t);
        r = longint'(a) + (prod >>> 16);
        if (r < 0)
            r = 0;
        if (r > 65535)
            r = 65535;
        return r[15:0];
    endfunction

    // Apply one request to the point list and return the result it must produce
    function automatic curve_resp_t predict_response(logic [1:0] cmd, logic [15:0] px,
                                                     logic [15:0] py, logic [16:0] t_in);
        curve_resp_t r;
        logic [15:0] wx [MAX_PTS];
        logic [15:0] wy [MAX_PTS];
        logic [16:0] t;
        int          n;
        int          i;
        r.cx = '0;
        r.cy = '0;
        r.st = STAT_DONE;
        t = (t_in > T_ONE) ? T_ONE : t_in;
        case (cmd)
            CMD_APPEND:
            begin
                if (held_pts < MAX_PTS)
                begin
                    pts_x[held_pts] = px;
                    pts_y[held_pts] = py;
                    held_pts++;
                end
                else
                begin
                    held_pts = 0;
                    r.st = STAT_OVERFLOW;
                end
            end
            CMD_REMOVE:
            begin
                if (held_pts > 0)
                    held_pts--;
            end
            CMD_CLEAR:
            begin
                held_pts = 0;
            end
            default:
            begin
                if (held_pts == 0)
                    r.st = STAT_EMPTY;
                else
                begin
                    for (i = 0; i < held_pts; i++)
                    begin
                        wx[i] = pts_x[i];
                        wy[i] = pts_y[i];
                    end
                    // collapse the chain one point per pass
                    for (n = held_pts; n > 1; n--)
                        for (i = 0; i + 1 < n; i++)
                        begin
                            wx[i] = lerp_coord(wx[i], wx[i+1], t);
                            wy[i] = lerp_coord(wy[i], wy[i+1], t);
                        end
                    r.cx = wx[0];
                    r.cy = wy[0];
                end
            end
        endcase
        r.count = held_pts[6:0];
        return r;
    endfunction

    task automatic queue_req(cmd_t cmd, logic [15:0] px, logic [15:0] py, logic [16:0] t,
                             bit hold_for_drain = 1'b0);
        curve_req_t r;
        r.cmd = cmd;
        r.px = px;
        r.py = py;
        r.t = t;
        r.hold_for_drain = hold_for_drain;
        req_q.push_back(r);
    endtask

    function automatic logic [15:0] rand_coord();
        return 16'($urandom_range(0, 65535));
    endfunction

    // Bias t toward the ends and the saturating range
    function automatic logic [16:0] pick_t();
        case ($urandom_range(0, 7))
            0:       return 17'd0;
            1:       return T_ONE;
            2:       return 17'($urandom_range(65537, 131071));
            3:       return 17'($urandom_range(1, 255));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic queue_appends(int k);
        repeat (k)
            queue_req(CMD_APPEND, rand_coord(), rand_coord(), 17'($urandom_range(0, 131071)));
    endtask

    task automatic queue_evals(int k);
        repeat (k)
            queue_req(CMD_EVAL, rand_coord(), rand_coord(), pick_t());
    endtask

    task automatic build_requests();
        int  kind;
        bit  drain;
        // Empty list, single point, both extremes and saturating t
        queue_req(CMD_EVAL,   rand_coord(), rand_coord(), 17'd0);
        queue_req(CMD_REMOVE, rand_coord(), rand_coord(), 17'h1FFFF);
        queue_req(CMD_CLEAR,  rand_coord(), rand_coord(), 17'd0);
        queue_req(CMD_APPEND, 16'h0000, 16'h0000, 17'd0);
        queue_req(CMD_EVAL,   rand_coord(), rand_coord(), 17'h1FFFF);
        queue_req(CMD_APPEND, 16'hFFFF, 16'hFFFF, 17'h1FFFF);
        queue_req(CMD_EVAL,   16'hFFFF, 16'hFFFF, 17'd0);
        queue_req(CMD_EVAL,   16'h0000, 16'h0000, T_ONE);
        queue_req(CMD_EVAL,   rand_coord(), rand_coord(), 17'h08000);
        // Falling segment exercises the floor on negative differences
        queue_req(CMD_APPEND, 16'h0000, 16'h0001, 17'd0);
        queue_req(CMD_EVAL,   rand_coord(), rand_coord(), 17'd1);
        queue_req(CMD_EVAL,   rand_coord(), rand_coord(), 17'd65535);
        queue_req(CMD_EVAL,   rand_coord(), rand_coord(), 17'd65537);
        queue_req(CMD_REMOVE, rand_coord(), rand_coord(), 17'd0);
        queue_req(CMD_EVAL,   rand_coord(), rand_coord(), 17'h04000);
        queue_req(CMD_REMOVE, rand_coord(), rand_coord(), 17'd0);
        queue_req(CMD_REMOVE, rand_coord(), rand_coord(), 17'd0);
        queue_req(CMD_REMOVE, rand_coord(), rand_coord(), 17'd0);
        queue_req(CMD_APPEND, 16'hAAAA, 16'h5555, 17'h1FFFF);
        queue_req(CMD_CLEAR,  16'hFFFF, 16'hFFFF, 17'h1FFFF);
        queue_req(CMD_EVAL,   rand_coord(), rand_coord(), T_ONE);
        queue_req(CMD_APPEND, 16'h1234, 16'hFEDC, 17'd0);
        queue_req(CMD_EVAL,   rand_coord(), rand_coord(), 17'd0);

        // Fill the list, trim and refill, then overflow it; hold off until idle first
        queue_req(CMD_CLEAR, rand_coord(), rand_coord(), pick_t(), 1'b1);
        queue_appends(MAX_PTS);
        queue_evals(1);
        queue_req(CMD_REMOVE, rand_coord(), rand_coord(), pick_t());
        queue_appends(1);
        queue_req(CMD_EVAL, rand_coord(), rand_coord(), T_ONE);
        queue_appends(1);
        queue_evals(1);

        // Mostly well-formed build-and-evaluate sequences, some noise
        while (req_q.size() < TOTAL_REQS)
        begin
            kind = $urandom_range(0, 9);
            drain = ($urandom_range(0, 15) == 0);
            case (kind)
                0, 1, 2, 3, 4, 5:
                begin
                    if ($urandom_range(0, 3) != 0 || drain)
                        queue_req(CMD_CLEAR, rand_coord(), rand_coord(), pick_t(), drain);
                    queue_appends(($urandom_range(0, 7) == 0) ? $urandom_range(7, 24)
                                                              : $urandom_range(1, 6));
                    queue_evals($urandom_range(1, 3));
                    if ($urandom_range(0, 1) == 1)
                    begin
                        queue_req(CMD_REMOVE, rand_coord(), rand_coord(), pick_t());
                        queue_evals(1);
                    end
                end
                6:
                begin
                    repeat ($urandom_range(1, 4))
                        queue_req(cmd_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                                  17'($urandom_range(0, 131071)));
                end
                7:
                begin
                    queue_evals($urandom_range(1, 3));
                end
                8:
                begin
                    repeat ($urandom_range(1, 3))
                        queue_req(CMD_REMOVE, rand_coord(), rand_coord(), pick_t());
                end
                default:
                begin
                    queue_appends(1);
                end
            endcase
        end
    endtask

    // Drive requests in bursts; hold the payload until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            command    <= CMD_CLEAR;
            point_x    <= '0;
            point_y    <= '0;
            param_t    <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (req_q.size() == 0 ||
                     (req_q[0].hold_for_drain && !(results_drained && !in_valid)))
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                next_req = req_q.pop_front();
                in_valid <= 1'b1;
                command  <= next_req.cmd;
                point_x  <= next_req.px;
                point_y  <= next_req.py;
                param_t  <= next_req.t;
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
                end
                else
                    burst_left--;
            end
        end
    end

    // Stall the result side in short and long stretches, with calm periods
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
            calm_left  = 0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (calm_left != 0)
                calm_left--;
            else if ($urandom_range(0, 99) < 3)
                calm_left = $urandom_range(20, 200);
            if (calm_left == 0 && $urandom_range(0, 3) == 0)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                         : $urandom_range(0, 3);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Predict on each accepted request, check each accepted result
    always @(posedge clk)
    begin
        curve_resp_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                resp_q.push_back(predict_response(command, point_x, point_y, param_t));
            if (out_valid && out_ready)
            begin
                if (resp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result x=%h y=%h status=%0d count=%0d",
                                 $realtime, curve_x, curve_y, status, point_count);
                end
                else
                begin
                    want = resp_q.pop_front();
                    if (curve_x !== want.cx || curve_y !== want.cy ||
                        status !== want.st || point_count !== want.count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"[%0t] mismatch: expected x=%h y=%h status=%0d count=%0d,",
                                      " got x=%h y=%h status=%0d count=%0d"},
                                     $realtime, want.cx, want.cy, want.st, want.count,
                                     curve_x, curve_y, status, point_count);
                    end
                end
            end
            results_drained <= (resp_q.size() == 0);
        end
    end

    // End the run if neither side moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        build_requests();
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        // Wait for all requests to go in and all results to come out
        while (req_q.size() != 0 || in_valid || resp_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
        if (resp_q.size() != 0)
        begin
            $display("%0d expected results never arrived", resp_q.size());
            mismatches += resp_q.size();
        end
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
